FILE: design/xfc_pkg.sv
// Shared types and constants for the XOR frame checker.
`default_nettype none
package xfc_pkg;

  // Frame layout and limits
  localparam logic [7:0] MAX_PAYLOAD   = 8'd64;
  localparam logic [7:0] MIN_FRAME     = 8'd5;
  localparam logic [7:0] PAYLOAD_START = 8'd4;
  localparam logic [7:0] POS_MAX       = 8'd255;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CHECK  = 2'd2
  } status_t;

  // Work for the back part, produced by one accepted byte
  typedef struct packed {
    logic       has_payload;
    logic       has_status;
    logic [7:0] data_byte;
    logic [7:0] command;
    logic [7:0] payload_length;
    status_t    status;
  } entry_t;

  // Front to queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage
`default_nettype wire

FILE: design/xfc_in_if.sv
// Byte input channel of the XOR frame checker.
`default_nettype none
interface xfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] received_byte;
  logic       frame_end;

  modport source (output valid, output received_byte, output frame_end, input ready);
  modport sink   (input valid, input received_byte, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: design/xfc_out_if.sv
// Result output channel of the XOR frame checker.
`default_nettype none
interface xfc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] command;
  logic [7:0] payload_length;
  logic [1:0] status;
  logic       end_of_run;

  modport source (output valid, output kind, output data_byte, output command,
                  output payload_length, output status, output end_of_run,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input command,
                  input payload_length, input status, input end_of_run,
                  output ready);
endinterface
`default_nettype wire

FILE: design/xor_frame_checker_top.sv
// Top level of the XOR frame checker.
// Takes one frame byte per clock on rx (last byte flagged by frame_end) and emits
// results on tx: a payload result for every payload byte and a status result on
// the last byte, carrying command, declared length and status (0 ok, 1 length
// error, 2 header or checksum error; discard the payload unless it is 0). The
// front accepts a byte every cycle while the work queue has room; the back
// emits one result per cycle through its output register while tx is ready; a
// last byte that is also a payload byte gives a payload and then a status result.
// A result passes the work queue and then the output register before tx; a
// stalled tx fills the queue and then holds off rx. The user must write sync_word
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
`default_nettype none
module xor_frame_checker_top #(
  parameter int unsigned QUEUE_DEPTH = xfc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  xfc_in_if.sink           rx,
  xfc_out_if.source        tx
);
  import xfc_pkg::*;

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  xfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx),
    .full      (full),
    .push      (push)
  );

  xfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  xfc_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .tx   (tx)
  );

endmodule
`default_nettype wire

FILE: design/xfc_front.sv
// Front part: accepts frame bytes, tracks frame state and classifies each item.
`default_nettype none
module xfc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  xfc_in_if.sink             rx,
  input  wire logic          full,
  output xfc_pkg::push_t     push
);
  import xfc_pkg::*;

  logic [15:0] sync_word;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  header_high, header_high_next;
  logic        header_mismatch, header_mismatch_next;
  logic [7:0]  saved_command, saved_command_next;
  logic [7:0]  saved_length, saved_length_next;
  logic        checksum_matched, checksum_matched_next;

  logic        accept;
  logic        len_ok;
  logic [8:0]  ck_pos;
  logic [8:0]  pos_wide;
  logic [8:0]  need_count;
  logic        have_payload;
  status_t     frame_status;

  assign rx.ready = !full;
  assign accept   = rx.valid && rx.ready;

  // Classify the byte by its position in the frame
  always_comb begin
    len_ok                = (saved_length <= MAX_PAYLOAD);
    ck_pos                = {1'b0, saved_length} + {1'b0, PAYLOAD_START};
    pos_wide              = {1'b0, byte_position};
    have_payload          = 1'b0;
    running_xor_next      = running_xor;
    header_high_next      = header_high;
    header_mismatch_next  = header_mismatch;
    saved_command_next    = saved_command;
    saved_length_next     = saved_length;
    checksum_matched_next = checksum_matched;
    if (byte_position == 8'd0) begin
      header_high_next = rx.received_byte;
      running_xor_next = rx.received_byte;
    end else if (byte_position == 8'd1) begin
      header_mismatch_next = ({header_high, rx.received_byte} != sync_word);
      running_xor_next     = running_xor ^ rx.received_byte;
    end else if (byte_position == 8'd2) begin
      saved_command_next = rx.received_byte;
      running_xor_next   = running_xor ^ rx.received_byte;
    end else if (byte_position == 8'd3) begin
      saved_length_next = rx.received_byte;
      running_xor_next  = running_xor ^ rx.received_byte;
    end else if (len_ok && (pos_wide < ck_pos)) begin
      have_payload     = 1'b1;
      running_xor_next = running_xor ^ rx.received_byte;
    end else if (len_ok && (pos_wide == ck_pos)) begin
      checksum_matched_next = (running_xor == rx.received_byte);
    end
    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                    : byte_position + 8'd1;
  end

  // Work out the frame status, first failing check wins
  always_comb begin
    need_count = {1'b0, MIN_FRAME} + {1'b0, saved_length_next};
    if (byte_position_next < MIN_FRAME) begin
      frame_status = ST_LENGTH;
    end else if (header_mismatch_next) begin
      frame_status = ST_CHECK;
    end else if (saved_length_next > MAX_PAYLOAD) begin
      frame_status = ST_LENGTH;
    end else if ({1'b0, byte_position_next} < need_count) begin
      frame_status = ST_LENGTH;
    end else if (!checksum_matched_next) begin
      frame_status = ST_CHECK;
    end else begin
      frame_status = ST_OK;
    end
  end

  // Hand work to the queue only when the item causes a result
  always_comb begin
    push.valid                = accept && (have_payload || rx.frame_end);
    push.entry.has_payload    = have_payload;
    push.entry.has_status     = rx.frame_end;
    push.entry.data_byte      = rx.received_byte;
    push.entry.command        = saved_command_next;
    push.entry.payload_length = saved_length_next;
    push.entry.status         = frame_status;
  end

  // Hold the expected header
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= '0;
    end else if (cfg_we) begin
      sync_word <= cfg_wdata;
    end
  end

  // Advance frame state; drop it at the end of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_xor      <= '0;
      header_high      <= '0;
      header_mismatch  <= 1'b0;
      saved_command    <= '0;
      saved_length     <= '0;
      checksum_matched <= 1'b0;
    end else if (accept) begin
      if (rx.frame_end) begin
        byte_position    <= '0;
        running_xor      <= '0;
        header_high      <= '0;
        header_mismatch  <= 1'b0;
        saved_command    <= '0;
        saved_length     <= '0;
        checksum_matched <= 1'b0;
      end else begin
        byte_position    <= byte_position_next;
        running_xor      <= running_xor_next;
        header_high      <= header_high_next;
        header_mismatch  <= header_mismatch_next;
        saved_command    <= saved_command_next;
        saved_length     <= saved_length_next;
        checksum_matched <= checksum_matched_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A frame end always restarts the position count
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.frame_end) |=> (byte_position == 8'd0))
    else $error("position not cleared after frame end");

  // Payload is only ever passed out past the frame header
  a_payload_pos: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.entry.has_payload) |-> (byte_position >= PAYLOAD_START))
    else $error("payload item inside frame header");
`endif

endmodule
`default_nettype wire

FILE: design/xfc_queue.sv
// Short queue of classified work between the front and back parts.
`default_nettype none
module xfc_queue #(
  parameter int unsigned DEPTH = xfc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire xfc_pkg::push_t push,
  input  wire logic           pop,
  output logic                full,
  output xfc_pkg::head_t      head
);
  import xfc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Store pushed work
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The front never offers work into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

FILE: design/xfc_back.sv
// Back part: turns queued work into result items behind an output register.
`default_nettype none
module xfc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire xfc_pkg::head_t head,
  output logic                pop,
  xfc_out_if.source           tx
);
  import xfc_pkg::*;

  logic sub;
  logic sub_next;
  logic out_free;
  logic emit;
  logic pay_first;

  assign out_free  = !tx.valid || tx.ready;
  assign emit      = out_free && head.valid;
  assign pay_first = head.entry.has_payload && !sub;

  // Pick the next result of the head entry and pop after its last one
  always_comb begin
    pop      = 1'b0;
    sub_next = sub;
    if (emit) begin
      if (pay_first) begin
        if (head.entry.has_status) begin
          sub_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        pop      = 1'b1;
        sub_next = 1'b0;
      end
    end
  end

  // Hold output valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
      sub      <= 1'b0;
    end else begin
      sub <= sub_next;
      if (out_free) begin
        tx.valid <= head.valid;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      if (pay_first) begin
        tx.kind           <= KIND_PAYLOAD;
        tx.data_byte      <= head.entry.data_byte;
        tx.command        <= '0;
        tx.payload_length <= '0;
        tx.status         <= ST_OK;
        tx.end_of_run     <= !head.entry.has_status;
      end else begin
        tx.kind           <= KIND_STATUS;
        tx.data_byte      <= '0;
        tx.command        <= head.entry.command;
        tx.payload_length <= head.entry.payload_length;
        tx.status         <= head.entry.status;
        tx.end_of_run     <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A half-done entry always has both a payload and a status result
  a_sub_entry: assert property (@(posedge clk) disable iff (rst)
    sub |-> (head.valid && head.entry.has_payload && head.entry.has_status))
    else $error("split entry without two results");

  // Every queued entry carries at least one result
  a_entry_work: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (head.entry.has_payload || head.entry.has_status))
    else $error("queued entry causes no result");
`endif

endmodule
`default_nettype wire
